FILE: sv/twoo_pkg.sv
`default_nettype none
package twoo_pkg;
   localparam int COEF_BITS_DEF      = 21;
   localparam int CORDIC_STEPS_DEF   = 24;
   localparam int POSE_FRAC_BITS_DEF = 16;
   localparam int ROW_BITS           = 63;
   localparam int ADDR_BITS          = 6;
   localparam logic [31:0] INV_GAIN_Q31 = 32'd1304065748;

   typedef enum logic [ADDR_BITS-1:0] {
      REG_ROW_X = 6'd0, REG_ROW_Y = 6'd8, REG_ROW_TURN = 6'd16,
      REG_LIN_SHIFT = 6'd24, REG_TURN_SHIFT = 6'd32
   } reg_addr_type;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_REFER  = 1'b1;

   // arctangent table, binary-angle units
   function automatic logic [31:0] atan_units(input logic [4:0] i);
      logic [31:0] t [32];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
      return t[i];
   endfunction
endpackage
`default_nettype wire

FILE: sv/twoo_if.sv
`default_nettype none
interface twoo_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] count_a;
   logic [31:0] count_b;
   logic [31:0] count_c;
   modport source (output valid, opcode, count_a, count_b, count_c, input ready);
   modport sink (input valid, opcode, count_a, count_b, count_c, output ready);
endinterface

interface twoo_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [39:0] x_position;
   logic [39:0] y_position;
   logic [31:0] heading_angle;
   logic [24:0] heading_degrees;
   logic [39:0] body_dx;
   logic [39:0] body_dy;
   logic [31:0] body_dturn;
   modport source (output valid, valid_res, x_position, y_position, heading_angle,
      heading_degrees, body_dx, body_dy, body_dturn, input ready);
   modport sink (input valid, valid_res, x_position, y_position, heading_angle,
      heading_degrees, body_dx, body_dy, body_dturn, output ready);
endinterface
`default_nettype wire

FILE: sv/twoo_cordic.sv
`default_nettype none
// Iterative CORDIC rotator with gain correction through one shared multiplier.
module twoo_cordic import twoo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [39:0] x_in,
   input  wire logic [39:0] y_in,
   input  wire logic [31:0] angle,
   output logic             done,
   output logic [40:0]      x_out,
   output logic [40:0]      y_out
);
   localparam int XW = 44;
   typedef enum logic [2:0] {IDLE, ROT, MULX, MULY, FIN} state_type;

   state_type         state_ff;
   logic [4:0]        step_ff;
   logic signed [XW-1:0] cx_ff, cy_ff;
   logic signed [33:0]   z_ff;
   logic [63:0]       prod_hi_ff;
   logic [1:0]        part_ff;
   logic [40:0]       mag_ff;
   logic              neg_ff;
   logic [40:0]       rx_ff;

   logic signed [33:0]   z0;
   logic signed [XW-1:0] sx, sy;
   logic [40:0]          mag_x, mag_y;
   logic [52:0]          mul_a;
   logic [63:0]          r_full;
   logic [63:0]          b_lo;

   always_comb begin
      z0    = 34'(signed'(angle));
      sx    = cx_ff >>> step_ff;
      sy    = cy_ff >>> step_ff;
      mag_x = cx_ff[XW-1] ? 41'(-cx_ff) : 41'(cx_ff);
      mag_y = cy_ff[XW-1] ? 41'(-cy_ff) : 41'(cy_ff);
      // shared multiplier: high and low halves of the magnitude in turn
      mul_a = (part_ff == 2'd0) ? 53'(mag_ff[40:20]) : 53'(mag_ff[19:0]);
      b_lo  = 64'(mul_a) * 64'(INV_GAIN_Q31);
      r_full = (prod_hi_ff >> 11) +
         ((((prod_hi_ff & 64'h7FF) << 20) + b_lo + (64'd1 << 30)) >> 31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done     <= 1'b0;
      end else begin
         done <= (state_ff == FIN);
         case (state_ff)
            IDLE: if (start) begin
               // fold angles beyond a quarter turn
               if (z0 > 34'sd1073741824 || z0 < -34'sd1073741824) begin
                  cx_ff <= -XW'(signed'(x_in));
                  cy_ff <= -XW'(signed'(y_in));
                  z_ff  <= (z0 > 0) ? z0 - 34'sd2147483648 : z0 + 34'sd2147483648;
               end else begin
                  cx_ff <= XW'(signed'(x_in));
                  cy_ff <= XW'(signed'(y_in));
                  z_ff  <= z0;
               end
               step_ff  <= '0;
               state_ff <= ROT;
            end
            ROT: begin
               if (!z_ff[33]) begin
                  cx_ff <= cx_ff - sy;
                  cy_ff <= cy_ff + sx;
                  z_ff  <= z_ff - 34'(atan_units(step_ff));
               end else begin
                  cx_ff <= cx_ff + sy;
                  cy_ff <= cy_ff - sx;
                  z_ff  <= z_ff + 34'(atan_units(step_ff));
               end
               step_ff <= step_ff + 5'd1;
               if (32'(step_ff) == CORDIC_STEPS - 1) begin
                  state_ff <= MULX;
                  part_ff  <= 2'd2;
               end
            end
            MULX, MULY: begin
               if (part_ff == 2'd2) begin
                  // capture x magnitude once the last step has settled
                  mag_ff  <= mag_x;
                  neg_ff  <= cx_ff[XW-1];
                  part_ff <= 2'd0;
               end else if (part_ff == 2'd0) begin
                  prod_hi_ff <= b_lo;
                  part_ff    <= 2'd1;
               end else begin
                  part_ff <= 2'd0;
                  if (state_ff == MULX) begin
                     rx_ff    <= neg_ff ? 41'(-r_full) : 41'(r_full);
                     mag_ff   <= mag_y;
                     neg_ff   <= cy_ff[XW-1];
                     state_ff <= MULY;
                  end else begin
                     x_out    <= rx_ff;
                     y_out    <= neg_ff ? 41'(-r_full) : 41'(r_full);
                     state_ff <= FIN;
                  end
               end
            end
            FIN: begin
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // done is a one-cycle pulse out of the final state
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == IDLE && !$past(done)) else $error("done not single");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == IDLE && $past(start) && !$past(reset) |-> state_ff == ROT)
      else $error("start missed");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ROT |-> 32'(step_ff) < CORDIC_STEPS) else $error("step overrun");
endmodule
`default_nettype wire

FILE: sv/three_wheel_omni_odometry.sv
`default_nettype none
// An update result passes through the delta state, the row sums at one product per cycle
// on a shared multiplier, CORDIC_STEPS rotation steps, then CORDIC start, gain and pose.
// One item is taken at a time; the next is accepted only once the result is taken.
// Reference items and updates before reference give their result straight from the
// delta state.
// Synchronous active-high reset clears pose, counts and reference, restores registers.
module three_wheel_omni_odometry import twoo_pkg::*; #(
   parameter int COEF_BITS      = COEF_BITS_DEF,
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
   parameter int POSE_FRAC_BITS = POSE_FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   twoo_req_if.sink                  req,
   twoo_rsp_if.source                rsp,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [63:0]          csr_pwdata,
   output logic [63:0]               csr_prdata,
   output logic                      csr_pready
);
   typedef enum logic [2:0] {IDLE, DELTA, MAC, SHIFT, ROT, POSE, OUT} state_type;

   logic [ROW_BITS-1:0] row_x_ff, row_y_ff, row_t_ff;
   logic [5:0]          lin_sh_ff, turn_sh_ff;

   state_type           state_ff;
   logic [31:0]         last_ff [3];
   logic [31:0]         cur_ff [3];
   logic signed [31:0]  d_ff [3];
   logic [39:0]         pos_x_ff, pos_y_ff;
   logic [31:0]         head_ff;
   logic                refd_ff;
   logic [1:0]          row_ff, col_ff;
   logic signed [63:0]  acc_ff;
   logic [39:0]         dx_ff, dy_ff;
   logic [31:0]         dturn_ff;
   logic                cord_start_ff;
   logic                opc_ff;

   logic [ROW_BITS-1:0]       row_sel;
   logic signed [COEF_BITS-1:0] coef;
   logic signed [63:0]        prod, shifted;
   logic [5:0]                sh;
   logic [39:0]               sat_v;
   logic [31:0]               mid;
   logic                      cord_done;
   logic [40:0]               rot_x, rot_y;
   logic signed [41:0]        sum_x, sum_y;
   logic signed [39:0]        sx_v, sy_v;
   logic signed [37:0]        deg_full;

   assign csr_pready = 1'b1;

   // configuration writes and reads
   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= '0; row_y_ff <= '0; row_t_ff <= '0;
         lin_sh_ff <= 6'd20; turn_sh_ff <= 6'd20;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            REG_ROW_X:      row_x_ff   <= csr_pwdata[ROW_BITS-1:0];
            REG_ROW_Y:      row_y_ff   <= csr_pwdata[ROW_BITS-1:0];
            REG_ROW_TURN:   row_t_ff   <= csr_pwdata[ROW_BITS-1:0];
            REG_LIN_SHIFT:  lin_sh_ff  <= csr_pwdata[5:0];
            REG_TURN_SHIFT: turn_sh_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         REG_ROW_X:      csr_prdata = 64'(row_x_ff);
         REG_ROW_Y:      csr_prdata = 64'(row_y_ff);
         REG_ROW_TURN:   csr_prdata = 64'(row_t_ff);
         REG_LIN_SHIFT:  csr_prdata = 64'(lin_sh_ff);
         REG_TURN_SHIFT: csr_prdata = 64'(turn_sh_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // one coefficient times one delta per cycle
   always_comb begin
      case (row_ff)
         2'd0:    row_sel = row_x_ff;
         2'd1:    row_sel = row_y_ff;
         default: row_sel = row_t_ff;
      endcase
      coef    = COEF_BITS'(row_sel >> (32'(col_ff) * COEF_BITS));
      prod    = 64'(d_ff[col_ff]) * 64'(coef);
      sh      = (row_ff == 2'd2) ? turn_sh_ff : lin_sh_ff;
      shifted = acc_ff >>> sh;
      if (shifted > 64'sd549755813887)       sat_v = 40'h7F_FFFF_FFFF;
      else if (shifted < -64'sd549755813888) sat_v = 40'h80_0000_0000;
      else                                   sat_v = shifted[39:0];
      mid   = head_ff + 32'(signed'(dturn_ff) >>> 1);
      sum_x = 42'(signed'(pos_x_ff)) + 42'(signed'(rot_x));
      sum_y = 42'(signed'(pos_y_ff)) + 42'(signed'(rot_y));
      sx_v  = (sum_x > 42'sd549755813887) ? 40'sh7F_FFFF_FFFF :
              (sum_x < -42'sd549755813888) ? 40'sh80_0000_0000 : sum_x[39:0];
      sy_v  = (sum_y > 42'sd549755813887) ? 40'sh7F_FFFF_FFFF :
              (sum_y < -42'sd549755813888) ? 40'sh80_0000_0000 : sum_y[39:0];
      deg_full = (38'(signed'(head_ff)) * 38'sd45 +
                  (38'sd1 <<< (28 - POSE_FRAC_BITS))) >>> (29 - POSE_FRAC_BITS);
   end

   twoo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start_ff),
      .x_in(dx_ff), .y_in(dy_ff), .angle(mid),
      .done(cord_done), .x_out(rot_x), .y_out(rot_y)
   );

   assign req.ready = (state_ff == IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         refd_ff  <= 1'b0;
         pos_x_ff <= '0; pos_y_ff <= '0; head_ff <= '0;
         for (int k = 0; k < 3; k++) last_ff[k] <= '0;
         rsp.valid     <= 1'b0;
         cord_start_ff <= 1'b0;
      end else begin
         cord_start_ff <= (state_ff == SHIFT) && (row_ff == 2'd2);
         case (state_ff)
            IDLE: if (req.valid) begin
               cur_ff[0] <= req.count_a;
               cur_ff[1] <= req.count_b;
               cur_ff[2] <= req.count_c;
               opc_ff    <= req.opcode;
               state_ff  <= DELTA;
            end
            DELTA: begin
               rsp.valid_res <= 1'b0;
               rsp.x_position <= '0; rsp.y_position <= '0;
               rsp.heading_angle <= '0; rsp.heading_degrees <= '0;
               rsp.body_dx <= '0; rsp.body_dy <= '0; rsp.body_dturn <= '0;
               if (opc_ff == OP_REFER) begin
                  for (int k = 0; k < 3; k++) last_ff[k] <= cur_ff[k];
                  pos_x_ff <= '0; pos_y_ff <= '0; head_ff <= '0;
                  refd_ff  <= 1'b1;
                  rsp.valid <= 1'b1;
                  state_ff  <= OUT;
               end else if (!refd_ff) begin
                  rsp.valid <= 1'b1;
                  state_ff  <= OUT;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     d_ff[k]    <= cur_ff[k] - last_ff[k];
                     last_ff[k] <= cur_ff[k];
                  end
                  row_ff   <= 2'd0;
                  col_ff   <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= MAC;
               end
            end
            MAC: begin
               acc_ff <= acc_ff + prod;
               if (col_ff == 2'd2) state_ff <= SHIFT;
               else col_ff <= col_ff + 2'd1;
            end
            SHIFT: begin
               acc_ff <= '0;
               col_ff <= 2'd0;
               case (row_ff)
                  2'd0: dx_ff <= sat_v;
                  2'd1: dy_ff <= sat_v;
                  default: dturn_ff <= shifted[31:0];
               endcase
               if (row_ff == 2'd2) begin
                  state_ff <= ROT;
               end else begin
                  row_ff   <= row_ff + 2'd1;
                  state_ff <= MAC;
               end
            end
            ROT: if (cord_done) begin
               pos_x_ff <= sx_v;
               pos_y_ff <= sy_v;
               head_ff  <= head_ff + dturn_ff;
               state_ff <= POSE;
            end
            POSE: begin
               rsp.valid_res       <= 1'b1;
               rsp.x_position      <= pos_x_ff;
               rsp.y_position      <= pos_y_ff;
               rsp.heading_angle   <= head_ff;
               rsp.heading_degrees <= deg_full[24:0];
               rsp.body_dx         <= dx_ff;
               rsp.body_dy         <= dy_ff;
               rsp.body_dturn      <= dturn_ff;
               rsp.valid           <= 1'b1;
               state_ff            <= OUT;
            end
            OUT: if (rsp.ready) begin
               rsp.valid <= 1'b0;
               state_ff  <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> state_ff == OUT) else $error("result outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while result pending");
   a_valid_needs_ref: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.valid_res |-> refd_ff) else $error("pose without reference");
endmodule
`default_nettype wire
